@@ rtl/bsvm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsvm_pkg
// Shared constants and types for the byte stack VM executor: opcodes, fault
// codes, controller phases, execution flows and the control/status bundles.
// ----------------------------------------------------------------------------
package bsvm_pkg;

  localparam int NUM_REGS_DEF    = 16;
  localparam int STACK_DEPTH_DEF = 4096;
  localparam int DATA_DEPTH_DEF  = 4096;

  // instruction codes
  localparam logic [7:0] OPC_EXIT    = 8'd0;
  localparam logic [7:0] OPC_RET     = 8'd1;
  localparam logic [7:0] OPC_END     = 8'd2;
  localparam logic [7:0] OPC_JUMP    = 8'd3;
  localparam logic [7:0] OPC_SKIP    = 8'd4;
  localparam logic [7:0] OPC_SETMODE = 8'd5;
  localparam logic [7:0] OPC_SET     = 8'd6;
  localparam logic [7:0] OPC_ADD     = 8'd7;
  localparam logic [7:0] OPC_SUB     = 8'd8;
  localparam logic [7:0] OPC_MUL     = 8'd9;
  localparam logic [7:0] OPC_DIV     = 8'd10;
  localparam logic [7:0] OPC_CMPE    = 8'd11;
  localparam logic [7:0] OPC_CMPH    = 8'd12;
  localparam logic [7:0] OPC_CMPL    = 8'd13;
  localparam logic [7:0] OPC_CMPHE   = 8'd14;
  localparam logic [7:0] OPC_CMPLE   = 8'd15;
  localparam logic [7:0] OPC_PUSH    = 8'd16;
  localparam logic [7:0] OPC_POP     = 8'd17;
  localparam logic [7:0] OPC_LDMODE  = 8'd18;
  localparam logic [7:0] OPC_LOAD    = 8'd19;

  // fault codes
  localparam logic [2:0] F_OK     = 3'd0;
  localparam logic [2:0] F_OPCODE = 3'd1;
  localparam logic [2:0] F_DIV0   = 3'd2;
  localparam logic [2:0] F_ADDR   = 3'd3;
  localparam logic [2:0] F_REG    = 3'd4;

  // datapath phases driven by the controller
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_CLR  = 4'd1;
  localparam logic [3:0] PH_RA   = 4'd2;
  localparam logic [3:0] PH_RB   = 4'd3;
  localparam logic [3:0] PH_RS1  = 4'd4;
  localparam logic [3:0] PH_RS2  = 4'd5;
  localparam logic [3:0] PH_CAP  = 4'd6;
  localparam logic [3:0] PH_CHK  = 4'd7;
  localparam logic [3:0] PH_MUL  = 4'd8;
  localparam logic [3:0] PH_DIV  = 4'd9;
  localparam logic [3:0] PH_MEM  = 4'd10;
  localparam logic [3:0] PH_WR   = 4'd11;
  localparam logic [3:0] PH_FIN  = 4'd12;

  // execution flows decided at the check phase
  localparam logic [2:0] FL_NONE = 3'd0;
  localparam logic [2:0] FL_W1   = 3'd1;
  localparam logic [2:0] FL_MUL  = 3'd2;
  localparam logic [2:0] FL_DIV  = 3'd3;
  localparam logic [2:0] FL_PUSH = 3'd4;
  localparam logic [2:0] FL_POP  = 3'd5;
  localparam logic [2:0] FL_LOAD = 3'd6;
  localparam logic [2:0] FL_LDM  = 3'd7;

  // register write index select
  localparam logic [1:0] WI_A  = 2'd0;
  localparam logic [1:0] WI_SP = 2'd1;
  localparam logic [1:0] WI_LA = 2'd2;
  localparam logic [1:0] WI_LP = 2'd3;

  // register write value select
  localparam logic [1:0] WV_D = 2'd0;
  localparam logic [1:0] WV_N = 2'd1;
  localparam logic [1:0] WV_A = 2'd2;

  typedef struct packed {
    logic [3:0] phase;
    logic       accept;
    logic       fin;
    logic       wr_en;
    logic [1:0] wr_idx;
    logic [1:0] wr_val;
  } cmd_t;

  typedef struct packed {
    logic [2:0] flow;
    logic       clr_last;
    logic       mul_done;
    logic       div_done;
    logic       mem_done;
  } sts_t;

endpackage

@@ rtl/byte_stack_vm_executor.sv @@
// ----------------------------------------------------------------------------
// byte_stack_vm_executor
// Executes one fetched instruction per input beat against a register file,
// a byte stack and a data area, and returns the next instruction number.
// ----------------------------------------------------------------------------
// After reset the block zeroes the byte stack (one byte a cycle through
// its single write port) and holds in_ready low. Each item then runs
// through a sequence of steps (accept, four register file reads through
// its one read port, capture, check, finish) plus: none, one or two
// register writes; for push, pop and load a byte move, one byte at a time
// (the stack and data area each have one port); a multiply on the shared
// 32x32 multiplier; and for divide one quotient bit a cycle. A finished
// result sits in the output register while the next beat is accepted.
module byte_stack_vm_executor #(
  parameter int NUM_REGS    = bsvm_pkg::NUM_REGS_DEF,
  parameter int STACK_DEPTH = bsvm_pkg::STACK_DEPTH_DEF,
  parameter int DATA_DEPTH  = bsvm_pkg::DATA_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_opcode,
  input  logic [63:0] in_first_operand,
  input  logic [63:0] in_second_operand,
  input  logic [11:0] in_data_addr,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_instruction,
  output logic        out_halted,
  output logic [2:0]  out_fault
);

  bsvm_pkg::cmd_t cmd;
  bsvm_pkg::sts_t sts;

  bsvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsvm_dpath #(
    .NUM_REGS    (NUM_REGS),
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_DEPTH  (DATA_DEPTH)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_op),
    .in_opcode            (in_opcode),
    .in_first_operand     (in_first_operand),
    .in_second_operand    (in_second_operand),
    .in_data_addr         (in_data_addr),
    .in_data_byte         (in_data_byte),
    .out_next_instruction (out_next_instruction),
    .out_halted           (out_halted),
    .out_fault            (out_fault)
  );

endmodule

@@ rtl/bsvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsvm_ctrl
// Sequencer: clears the stack after reset, then walks each item through
// operand reads, check, multi-cycle units, byte moves and register writes.
// ----------------------------------------------------------------------------
module bsvm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bsvm_pkg::sts_t  sts,
  output bsvm_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RA   = 4'd2;
  localparam logic [3:0] S_RB   = 4'd3;
  localparam logic [3:0] S_RS1  = 4'd4;
  localparam logic [3:0] S_RS2  = 4'd5;
  localparam logic [3:0] S_CAP  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_MEM  = 4'd10;
  localparam logic [3:0] S_W1   = 4'd11;
  localparam logic [3:0] S_W2   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [2:0] flow_r, flow_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    flow_nxt   = flow_r;
    cmd        = '0;
    cmd.phase  = bsvm_pkg::PH_IDLE;
    cmd.wr_idx = bsvm_pkg::WI_A;
    cmd.wr_val = bsvm_pkg::WV_D;
    unique case (state_r)
      S_CLR: begin
        cmd.phase = bsvm_pkg::PH_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_RA;
      end
      S_RA: begin
        cmd.phase = bsvm_pkg::PH_RA;
        state_nxt = S_RB;
      end
      S_RB: begin
        cmd.phase = bsvm_pkg::PH_RB;
        state_nxt = S_RS1;
      end
      S_RS1: begin
        cmd.phase = bsvm_pkg::PH_RS1;
        state_nxt = S_RS2;
      end
      S_RS2: begin
        cmd.phase = bsvm_pkg::PH_RS2;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.phase = bsvm_pkg::PH_CAP;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.phase = bsvm_pkg::PH_CHK;
        flow_nxt  = sts.flow;
        case (sts.flow)
          bsvm_pkg::FL_NONE:                    state_nxt = S_FIN;
          bsvm_pkg::FL_MUL:                     state_nxt = S_MUL;
          bsvm_pkg::FL_DIV:                     state_nxt = S_DIV;
          bsvm_pkg::FL_PUSH, bsvm_pkg::FL_LOAD: state_nxt = S_MEM;
          default:                              state_nxt = S_W1;
        endcase
      end
      S_MUL: begin
        cmd.phase = bsvm_pkg::PH_MUL;
        if (sts.mul_done) state_nxt = S_W1;
      end
      S_DIV: begin
        cmd.phase = bsvm_pkg::PH_DIV;
        if (sts.div_done) state_nxt = S_W1;
      end
      S_MEM: begin
        cmd.phase = bsvm_pkg::PH_MEM;
        if (sts.mem_done) state_nxt = (flow_r == bsvm_pkg::FL_POP) ? S_W2 : S_W1;
      end
      S_W1: begin
        cmd.phase = bsvm_pkg::PH_WR;
        cmd.wr_en = 1'b1;
        case (flow_r)
          bsvm_pkg::FL_PUSH: begin
            cmd.wr_idx = bsvm_pkg::WI_SP;
            cmd.wr_val = bsvm_pkg::WV_N;
            state_nxt  = S_FIN;
          end
          bsvm_pkg::FL_POP: begin
            // stack pointer first, then the byte moves
            cmd.wr_idx = bsvm_pkg::WI_SP;
            cmd.wr_val = bsvm_pkg::WV_N;
            state_nxt  = S_MEM;
          end
          bsvm_pkg::FL_LDM: begin
            cmd.wr_idx = bsvm_pkg::WI_LA;
            cmd.wr_val = bsvm_pkg::WV_A;
            state_nxt  = S_W2;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_W2: begin
        cmd.phase  = bsvm_pkg::PH_WR;
        cmd.wr_en  = 1'b1;
        cmd.wr_idx = (flow_r == bsvm_pkg::FL_LDM) ? bsvm_pkg::WI_LP : bsvm_pkg::WI_A;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.phase = bsvm_pkg::PH_FIN;
        cmd.fin   = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      flow_r      <= bsvm_pkg::FL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flow_r      <= flow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_RA))
    else $error("accepted beat did not start operand reads");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the finish step");
`endif

endmodule

@@ rtl/bsvm_dpath.sv @@
// ----------------------------------------------------------------------------
// bsvm_dpath
// Datapath: register file, byte stack, data area, shared 32x32 multiplier,
// bit-serial divider, byte mover and the architectural state.
// ----------------------------------------------------------------------------
module bsvm_dpath #(
  parameter int NUM_REGS    = bsvm_pkg::NUM_REGS_DEF,
  parameter int STACK_DEPTH = bsvm_pkg::STACK_DEPTH_DEF,
  parameter int DATA_DEPTH  = bsvm_pkg::DATA_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bsvm_pkg::cmd_t      cmd,
  output bsvm_pkg::sts_t      sts,
  input  logic                in_op,
  input  logic [7:0]          in_opcode,
  input  logic [63:0]         in_first_operand,
  input  logic [63:0]         in_second_operand,
  input  logic [11:0]         in_data_addr,
  input  logic [7:0]          in_data_byte,
  output logic [31:0]         out_next_instruction,
  output logic                out_halted,
  output logic [2:0]          out_fault
);

  localparam int RW  = $clog2(NUM_REGS);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int MAW = (SAW > DAW) ? SAW : DAW;

  localparam logic [RW-1:0] IDX_RA = RW'(NUM_REGS - 4);
  localparam logic [RW-1:0] IDX_SP = RW'(NUM_REGS - 3);
  localparam logic [RW-1:0] IDX_LA = RW'(NUM_REGS - 2);
  localparam logic [RW-1:0] IDX_LP = RW'(NUM_REGS - 1);

  function automatic logic [3:0] clamp8(input logic [63:0] v);
    return (v > 64'd8) ? 4'd8 : v[3:0];
  endfunction

  // latched item
  logic        op_r;
  logic [7:0]  opcode_r;
  logic [63:0] a_r, b_r;
  logic [11:0] data_addr_r;
  logic [7:0]  data_byte_r;

  // architectural state
  logic [31:0] pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  logic        fir_r, fir_nxt;
  logic        sir_r, sir_nxt;
  logic [2:0]  fault_r, fault_nxt;

  // working registers
  logic [63:0] x_r, x_nxt, y_r, y_nxt, s_r, d_r, d_nxt, n_r, n_nxt;
  logic        la_zero_r;
  logic [3:0]  cnt_r, cnt_nxt, i_r;
  logic [MAW-1:0] ma_r, ma_nxt, maddr;
  logic        msrc_r, msrc_nxt, mwr_r, mwr_nxt;
  logic        pend_r;
  logic [2:0]  bi_r;
  logic [5:0]  it_r;
  logic [63:0] rem_r, prod_r;
  logic [2:0]  flow_nxt;
  logic        dwe;

  // register file
  logic [63:0]       rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [RW-1:0]     rf_ra, rf_wa;
  logic [63:0]       rf_q_r, rf_rd, rf_wd;
  logic              vld_q_r;

  // stack and data area
  logic [7:0]     stack_mem [STACK_DEPTH];
  logic [7:0]     data_mem [DATA_DEPTH];
  logic [7:0]     stack_q_r, data_q_r, st_wd;
  logic [SAW-1:0] cl_r, st_wa;
  logic           st_we;
  logic [DAW+11:0] dext;

  logic        a_ok, b_ok, cond, mem_issue;
  logic [63:0] xv, yv, pop_n;
  logic [3:0]  cb, cy;
  logic        stk_ok_push, stk_ok_ld, dat_ok_ld, dat_ok_wr;
  logic [64:0] rem_sh, rem_sub;
  logic        ge;
  logic [31:0] mul_a, mul_b;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r        <= in_op;
      opcode_r    <= in_opcode;
      a_r         <= in_first_operand;
      b_r         <= in_second_operand;
      data_addr_r <= in_data_addr;
      data_byte_r <= in_data_byte;
    end
  end

  // ---------------------------------------------------------------- reads
  always_comb begin
    case (cmd.phase)
      bsvm_pkg::PH_RB:  rf_ra = b_r[RW-1:0];
      bsvm_pkg::PH_RS1: begin
        if (opcode_r == bsvm_pkg::OPC_RET) rf_ra = IDX_RA;
        else if (opcode_r == bsvm_pkg::OPC_LOAD) rf_ra = IDX_LP;
        else rf_ra = IDX_SP;
      end
      bsvm_pkg::PH_RS2: rf_ra = IDX_LA;
      default:          rf_ra = a_r[RW-1:0];
    endcase
    case (cmd.wr_idx)
      bsvm_pkg::WI_SP: rf_wa = IDX_SP;
      bsvm_pkg::WI_LA: rf_wa = IDX_LA;
      bsvm_pkg::WI_LP: rf_wa = IDX_LP;
      default:         rf_wa = a_r[RW-1:0];
    endcase
    case (cmd.wr_val)
      bsvm_pkg::WV_N: rf_wd = n_r;
      bsvm_pkg::WV_A: rf_wd = a_r;
      default:        rf_wd = d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) rf_mem[rf_wa] <= rf_wd;
    rf_q_r <= rf_mem[rf_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (cmd.wr_en) vld_r[rf_wa] <= 1'b1;
      vld_q_r <= vld_r[rf_ra];
    end
  end

  assign rf_rd = vld_q_r ? rf_q_r : 64'd0;

  // ------------------------------------------------------------ memories
  assign maddr     = ma_r + MAW'(i_r);
  assign mem_issue = (cmd.phase == bsvm_pkg::PH_MEM) && (i_r != cnt_r);
  assign dext      = {{DAW{1'b0}}, data_addr_r};

  always_comb begin
    st_we = 1'b0;
    st_wa = maddr[SAW-1:0];
    st_wd = x_r[{i_r[2:0], 3'b000} +: 8];
    if (cmd.phase == bsvm_pkg::PH_CLR) begin
      st_we = 1'b1;
      st_wa = cl_r;
      st_wd = 8'd0;
    end else if (mem_issue && mwr_r) begin
      st_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_wa] <= st_wd;
    stack_q_r <= stack_mem[maddr[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dwe) data_mem[dext[DAW-1:0]] <= data_byte_r;
    data_q_r <= data_mem[maddr[DAW-1:0]];
  end

  // --------------------------------------------------------------- check
  assign a_ok  = (a_r < 64'(NUM_REGS));
  assign b_ok  = (b_r < 64'(NUM_REGS));
  assign xv    = fir_r ? x_r : a_r;
  assign yv    = sir_r ? y_r : b_r;
  assign cb    = clamp8(b_r);
  assign cy    = clamp8(yv);
  assign pop_n = s_r - 64'(cb);
  assign stk_ok_push = (s_r <= 64'(STACK_DEPTH)) &&
                       (64'(cb) <= 64'(STACK_DEPTH) - s_r);
  assign stk_ok_ld   = (s_r <= 64'(STACK_DEPTH)) &&
                       (64'(cy) <= 64'(STACK_DEPTH) - s_r);
  assign dat_ok_ld   = (s_r <= 64'(DATA_DEPTH)) &&
                       (64'(cy) <= 64'(DATA_DEPTH) - s_r);
  assign dat_ok_wr   = ({20'd0, data_addr_r} < 32'(DATA_DEPTH));

  always_comb begin
    case (opcode_r)
      bsvm_pkg::OPC_CMPE:  cond = (xv == yv);
      bsvm_pkg::OPC_CMPH:  cond = (xv > yv);
      bsvm_pkg::OPC_CMPL:  cond = (xv < yv);
      bsvm_pkg::OPC_CMPHE: cond = (xv >= yv);
      default:             cond = (xv <= yv);
    endcase
  end

  always_comb begin
    flow_nxt  = bsvm_pkg::FL_NONE;
    fault_nxt = bsvm_pkg::F_OK;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    fir_nxt   = fir_r;
    sir_nxt   = sir_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    d_nxt     = d_r;
    n_nxt     = n_r;
    cnt_nxt   = cnt_r;
    ma_nxt    = ma_r;
    msrc_nxt  = msrc_r;
    mwr_nxt   = mwr_r;
    dwe       = 1'b0;
    if (op_r) begin
      if (dat_ok_wr) dwe = (cmd.phase == bsvm_pkg::PH_CHK);
      else fault_nxt = bsvm_pkg::F_ADDR;
    end else if (!halt_r) begin
      pc_nxt = pc_r + 32'd1;
      unique case (opcode_r) inside
        bsvm_pkg::OPC_EXIT, bsvm_pkg::OPC_SKIP: ;
        bsvm_pkg::OPC_RET:  pc_nxt = s_r[31:0];
        bsvm_pkg::OPC_END: begin
          halt_nxt = 1'b1;
          pc_nxt   = pc_r;
        end
        bsvm_pkg::OPC_JUMP: pc_nxt = a_r[31:0];
        bsvm_pkg::OPC_SETMODE: begin
          fir_nxt = (a_r == 64'd1);
          sir_nxt = (b_r == 64'd1);
        end
        bsvm_pkg::OPC_SET: begin
          if (!a_ok) fault_nxt = bsvm_pkg::F_REG;
          else begin
            d_nxt    = b_r;
            flow_nxt = bsvm_pkg::FL_W1;
          end
        end
        bsvm_pkg::OPC_ADD, bsvm_pkg::OPC_SUB, bsvm_pkg::OPC_MUL, bsvm_pkg::OPC_DIV: begin
          if (!a_ok || (sir_r && !b_ok)) fault_nxt = bsvm_pkg::F_REG;
          else if (opcode_r == bsvm_pkg::OPC_ADD) begin
            d_nxt    = x_r + yv;
            flow_nxt = bsvm_pkg::FL_W1;
          end else if (opcode_r == bsvm_pkg::OPC_SUB) begin
            d_nxt    = x_r - yv;
            flow_nxt = bsvm_pkg::FL_W1;
          end else if (opcode_r == bsvm_pkg::OPC_MUL) begin
            y_nxt    = yv;
            d_nxt    = 64'd0;
            flow_nxt = bsvm_pkg::FL_MUL;
          end else if (yv == 64'd0) begin
            fault_nxt = bsvm_pkg::F_DIV0;
          end else begin
            y_nxt    = yv;
            d_nxt    = x_r;
            flow_nxt = bsvm_pkg::FL_DIV;
          end
        end
        [bsvm_pkg::OPC_CMPE:bsvm_pkg::OPC_CMPLE]: begin
          if ((fir_r && !a_ok) || (sir_r && !b_ok)) fault_nxt = bsvm_pkg::F_REG;
          else pc_nxt = pc_r + (cond ? 32'd1 : 32'd2);
        end
        bsvm_pkg::OPC_PUSH: begin
          if (fir_r && !a_ok) fault_nxt = bsvm_pkg::F_REG;
          else if (!stk_ok_push) fault_nxt = bsvm_pkg::F_ADDR;
          else begin
            x_nxt    = xv;
            cnt_nxt  = cb;
            ma_nxt   = s_r[MAW-1:0];
            msrc_nxt = 1'b0;
            mwr_nxt  = 1'b1;
            n_nxt    = s_r + 64'(cb);
            flow_nxt = bsvm_pkg::FL_PUSH;
          end
        end
        bsvm_pkg::OPC_POP: begin
          if (!a_ok) fault_nxt = bsvm_pkg::F_REG;
          else if ((s_r < 64'(cb)) || (s_r > 64'(STACK_DEPTH))) fault_nxt = bsvm_pkg::F_ADDR;
          else begin
            n_nxt    = pop_n;
            cnt_nxt  = cb;
            ma_nxt   = pop_n[MAW-1:0];
            msrc_nxt = 1'b0;
            mwr_nxt  = 1'b0;
            // popping into the stack pointer starts from its updated value
            d_nxt    = (a_r[RW-1:0] == IDX_SP) ? pop_n : x_r;
            flow_nxt = bsvm_pkg::FL_POP;
          end
        end
        bsvm_pkg::OPC_LDMODE: begin
          if (sir_r && !b_ok) fault_nxt = bsvm_pkg::F_REG;
          else begin
            d_nxt    = yv;
            flow_nxt = bsvm_pkg::FL_LDM;
          end
        end
        bsvm_pkg::OPC_LOAD: begin
          if (!a_ok || (sir_r && !b_ok)) fault_nxt = bsvm_pkg::F_REG;
          else if (la_zero_r ? !stk_ok_ld : !dat_ok_ld) fault_nxt = bsvm_pkg::F_ADDR;
          else begin
            cnt_nxt  = cy;
            ma_nxt   = s_r[MAW-1:0];
            msrc_nxt = !la_zero_r;
            mwr_nxt  = 1'b0;
            d_nxt    = x_r;
            flow_nxt = bsvm_pkg::FL_LOAD;
          end
        end
        default: fault_nxt = bsvm_pkg::F_OPCODE;
      endcase
    end
  end

  // ------------------------------------------------------ multiply/divide
  assign mul_a   = (it_r == 6'd2) ? x_r[63:32] : x_r[31:0];
  assign mul_b   = (it_r == 6'd1) ? y_r[63:32] : y_r[31:0];
  assign rem_sh  = {rem_r, d_r[63]};
  assign rem_sub = rem_sh - {1'b0, y_r};
  assign ge      = (rem_sh >= {1'b0, y_r});

  // ------------------------------------------------------------ payload
  always_ff @(posedge clk) begin
    case (cmd.phase)
      bsvm_pkg::PH_RB:  x_r <= rf_rd;
      bsvm_pkg::PH_RS1: y_r <= rf_rd;
      bsvm_pkg::PH_RS2: s_r <= rf_rd;
      bsvm_pkg::PH_CAP: la_zero_r <= (rf_rd == 64'd0);
      bsvm_pkg::PH_CHK: begin
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        d_r     <= d_nxt;
        n_r     <= n_nxt;
        cnt_r   <= cnt_nxt;
        ma_r    <= ma_nxt;
        msrc_r  <= msrc_nxt;
        mwr_r   <= mwr_nxt;
        fault_r <= fault_nxt;
        rem_r   <= 64'd0;
      end
      bsvm_pkg::PH_MUL: begin
        prod_r <= mul_a * mul_b;
        if (it_r == 6'd1) d_r <= prod_r;
        else if (it_r != 6'd0) d_r <= d_r + {prod_r[31:0], 32'd0};
      end
      bsvm_pkg::PH_DIV: begin
        rem_r <= ge ? rem_sub[63:0] : rem_sh[63:0];
        d_r   <= {d_r[62:0], ge};
      end
      bsvm_pkg::PH_MEM: begin
        bi_r <= i_r[2:0];
        if (pend_r) d_r[{bi_r, 3'b000} +: 8] <= msrc_r ? data_q_r : stack_q_r;
      end
      default: ;
    endcase
    if (cmd.fin) begin
      out_next_instruction <= pc_r;
      out_halted           <= halt_r;
      out_fault            <= fault_r;
    end
  end

  // ------------------------------------------------------------ control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= 32'd0;
      halt_r <= 1'b0;
      fir_r  <= 1'b1;
      sir_r  <= 1'b0;
      cl_r   <= '0;
      it_r   <= 6'd0;
      i_r    <= 4'd0;
      pend_r <= 1'b0;
    end else begin
      case (cmd.phase)
        bsvm_pkg::PH_CLR: cl_r <= cl_r + SAW'(1);
        bsvm_pkg::PH_CHK: begin
          pc_r   <= pc_nxt;
          halt_r <= halt_nxt;
          fir_r  <= fir_nxt;
          sir_r  <= sir_nxt;
          it_r   <= 6'd0;
          i_r    <= 4'd0;
          pend_r <= 1'b0;
        end
        bsvm_pkg::PH_MUL, bsvm_pkg::PH_DIV: it_r <= it_r + 6'd1;
        bsvm_pkg::PH_MEM: begin
          // issue one byte a cycle; read data lands in the cycle after its issue
          if (mem_issue) i_r <= i_r + 4'd1;
          pend_r <= mem_issue && !mwr_r;
        end
        default: ;
      endcase
    end
  end

  assign sts.flow     = flow_nxt;
  assign sts.clr_last = (cl_r == SAW'(STACK_DEPTH - 1));
  assign sts.mul_done = (it_r == 6'd3);
  assign sts.div_done = (it_r == 6'd63);
  assign sts.mem_done = (i_r == cnt_r) && !pend_r;

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped without reset");

  a_mem_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.phase == bsvm_pkg::PH_MEM) |-> (i_r <= cnt_r) && (cnt_r <= 4'd8))
    else $error("byte mover ran past its count");
`endif

endmodule
